### src/pfsa_pkg.sv
// Shared constants, codes and widths for the free frame stack allocator.
package pfsa_pkg;

  localparam int unsigned DEF_MAX_FRAMES = 16384;

  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned FNUM_W   = FRAME_W + 1;  // frame number up to 2^20 inclusive
  localparam int unsigned ADDED_W  = 15;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned OP_W     = 2;
  localparam int unsigned PAGE_SHIFT = 12;

  localparam logic [31:0] LOW_LIMIT  = 32'h0010_0000;
  localparam logic [32:0] PAGE_ROUND = 33'h0_0000_0FFF;
  localparam logic [FNUM_W-1:0] TOP_FRAME = FNUM_W'(1) << FRAME_W;

  localparam logic [7:0] TYPE_USABLE = 8'd1;

  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_MAPPED  = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTHING = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd4;

  localparam int unsigned PADDR_W = 3;
  localparam logic [0:0] REG_KERNEL_END = 1'b0;

endpackage

### src/page_frame_stack_allocator.sv
// Free frame stack allocator: frame stack in one RAM, add/alloc/free sequencer.
//
//  channel | handshake             | payload
//  --------+-----------------------+---------------------------------------------
//  in      | in_valid / in_stall   | op, region_base, region_length, region_type,
//          |                       | page_frame, kernel_page, writeable
//  out     | out_valid / out_stall | status, present, rw, user, frame, frames_added
//  cfg     | APB psel/penable      | kernel_end at byte address 0
//
// Free, the refused cases and unusable or low regions go from idle straight to the done state;
// allocate passes through a pop state because the stack RAM read is registered.
// Add-region of a usable entry goes through a prep state, then a run state that pushes
// one frame per cycle, set by the single RAM write port.
// A finished result waits in the output register; the next transaction is taken
// meanwhile, and the block holds only when its own result has nowhere to go.
// Reset (rst, synchronous) empties the stack and clears kernel_end; no RAM sweep.
module page_frame_stack_allocator
  import pfsa_pkg::*;
#(
  parameter int unsigned MAX_FRAMES = DEF_MAX_FRAMES
) (
  input  logic                clk,
  input  logic                rst,
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  // request channel
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [OP_W-1:0]     op,
  input  logic [31:0]         region_base,
  input  logic [31:0]         region_length,
  input  logic [7:0]          region_type,
  input  logic [FRAME_W-1:0]  page_frame,
  input  logic                kernel_page,
  input  logic                writeable,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] status,
  output logic                present,
  output logic                rw,
  output logic                user,
  output logic [FRAME_W-1:0]  frame,
  output logic [ADDED_W-1:0]  frames_added
);

  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned AW = $clog2(MAX_FRAMES);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_FRAMES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_POP  = 3'd1;
  localparam logic [2:0] S_PREP = 3'd2;
  localparam logic [2:0] S_RUN  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]         state;
  logic [CW-1:0]      stack_count;
  logic [31:0]        kernel_end;

  logic [FNUM_W-1:0]  cur;
  logic [FNUM_W-1:0]  end_frame;
  logic [ADDED_W-1:0] added;
  logic               wr_q;
  logic               kern_q;

  logic [STATUS_W-1:0] res_status;
  logic                res_present;
  logic                res_rw;
  logic                res_user;
  logic [FRAME_W-1:0]  res_frame;

  logic [FRAME_W-1:0] mem [MAX_FRAMES];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [FRAME_W-1:0] mem_wdata;
  logic [AW-1:0]      mem_raddr;
  logic [FRAME_W-1:0] mem_rdata;

  logic               in_fire;
  logic               out_free;
  logic               is_full;
  logic [32:0]        start_sum;
  logic [32:0]        end_sum;
  logic [FNUM_W-1:0]  start_in;
  logic [FNUM_W-1:0]  end_in;
  logic [FNUM_W-1:0]  kern_first;

  assign pready   = 1'b1;
  assign prdata   = (paddr[2:2] == REG_KERNEL_END) ? kernel_end : 32'd0;

  assign in_stall = (state != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign is_full  = (stack_count == FULL_COUNT);

  // round the base up and the clamped end down to whole frames
  assign start_sum = {1'b0, region_base} + PAGE_ROUND;
  assign end_sum   = {1'b0, region_base} + {1'b0, region_length};
  assign start_in  = start_sum[32:PAGE_SHIFT];
  assign end_in    = end_sum[32] ? TOP_FRAME : {1'b0, end_sum[31:PAGE_SHIFT]};
  assign kern_first = {1'b0, kernel_end[31:PAGE_SHIFT]} + FNUM_W'(1);

  assign mem_raddr = AW'(stack_count - CW'(1));
  assign mem_waddr = stack_count[AW-1:0];

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = page_frame;
    if (in_fire && op == OP_FREE && page_frame != '0 && !is_full) begin
      mem_we = 1'b1;
    end else if (state == S_RUN && cur < end_frame && !is_full) begin
      mem_we    = 1'b1;
      mem_wdata = cur[FRAME_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_end <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2:2] == REG_KERNEL_END) begin
      kernel_end <= pwdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      stack_count <= '0;
      out_valid   <= 1'b0;
    end else begin
      // drop the taken result unless a new one loads this cycle
      if (out_valid && !out_stall && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            wr_q        <= writeable;
            kern_q      <= kernel_page;
            added       <= '0;
            res_present <= 1'b0;
            res_rw      <= 1'b0;
            res_user    <= 1'b0;
            cur         <= start_in;
            end_frame   <= end_in;
            case (op)
              OP_ADD: begin
                res_status <= ST_OK;
                res_frame  <= '0;
                if (region_type == TYPE_USABLE && region_base >= LOW_LIMIT) begin
                  state <= S_PREP;
                end else begin
                  state <= S_DONE;
                end
              end
              OP_ALLOC: begin
                if (page_frame != '0) begin
                  res_status <= ST_MAPPED;
                  res_frame  <= page_frame;
                  state      <= S_DONE;
                end else if (stack_count == '0) begin
                  res_status <= ST_EMPTY;
                  res_frame  <= '0;
                  state      <= S_DONE;
                end else begin
                  // RAM read of the top entry is in flight
                  res_status  <= ST_OK;
                  stack_count <= stack_count - CW'(1);
                  state       <= S_POP;
                end
              end
              OP_FREE: begin
                state <= S_DONE;
                if (page_frame == '0) begin
                  res_status <= ST_NOTHING;
                  res_frame  <= '0;
                end else if (is_full) begin
                  res_status <= ST_FULL;
                  res_frame  <= page_frame;
                end else begin
                  res_status  <= ST_OK;
                  res_frame   <= '0;
                  stack_count <= stack_count + CW'(1);
                end
              end
              default: begin
                res_status <= ST_OK;
                res_frame  <= '0;
                state      <= S_DONE;
              end
            endcase
          end
        end
        S_POP: begin
          res_present <= 1'b1;
          res_rw      <= wr_q;
          res_user    <= !kern_q;
          res_frame   <= mem_rdata;
          state       <= S_DONE;
        end
        S_PREP: begin
          // skip frames at or below the kernel image
          if (kern_first > cur) begin
            cur <= kern_first;
          end
          state <= S_RUN;
        end
        S_RUN: begin
          if (cur >= end_frame) begin
            state <= S_DONE;
          end else if (is_full) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            stack_count <= stack_count + CW'(1);
            added       <= added + ADDED_W'(1);
            cur         <= cur + FNUM_W'(1);
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            status       <= res_status;
            present      <= res_present;
            rw           <= res_rw;
            user         <= res_user;
            frame        <= res_frame;
            frames_added <= added;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/pfsa_checker.sv
// Port-level checks for the free frame stack allocator, bound to the top level.
module pfsa_checker
  import pfsa_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_stall,
  input logic [STATUS_W-1:0] status,
  input logic                present,
  input logic                rw,
  input logic                user,
  input logic [FRAME_W-1:0]  frame,
  input logic [ADDED_W-1:0]  frames_added
);

  // hold a stalled transaction
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(frame) && $stable(status))
    else $error("stalled result changed");

  // frame 0 is never stacked, so a granted page always carries a frame
  a_grant_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && present |-> frame != '0)
    else $error("allocate granted frame 0");

  a_grant_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && present |-> status == ST_OK && frames_added == '0)
    else $error("grant with bad status or frame count");

  a_bits_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !present |-> !rw && !user)
    else $error("page bits set without grant");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind page_frame_stack_allocator pfsa_checker u_pfsa_checker (.*);
